/* rtl/odpq_pkg.sv */
// Shared types, constants and helpers for the ordered-dither palette quantizer.
// Depends on nothing; imported by rtl/ordered_dither_palette_quantizer.sv.
package odpq_pkg;

    // Default sizes
    localparam int PALETTE_DEPTH_DEF = 16;
    localparam int MAX_WIDTH_DEF     = 4096;

    // Stream widths
    localparam int S_TDATA_W = 56;  // 52 payload bits padded to whole bytes
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_ADDR_W-1:0] CFG_PALETTE_COUNT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_DITHER_ENABLE = 2'd2;

    // Field widths
    localparam int COUNT_W = 5;
    localparam int WIDTH_W = 13;
    localparam int INDEX_W = 4;
    localparam int COLOR_W = 24;
    localparam int CHAN_W  = 8;
    localparam int SQ_W    = 16;
    localparam int DIST_W  = 18;   // 3 * 255^2 fits in 18 bits

    // Item kinds
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_PIXEL = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef logic [3:0] t_bayer_row [4];
    localparam t_bayer_row BAYER_MAP [4] = '{
        '{4'd0,  4'd8,  4'd2,  4'd10},
        '{4'd12, 4'd4,  4'd14, 4'd6},
        '{4'd3,  4'd11, 4'd1,  4'd9},
        '{4'd15, 4'd7,  4'd13, 4'd5}
    };

    // Add the Bayer offset 4*m - 32 to one channel and clamp to 0..255.
    function automatic logic [CHAN_W-1:0] dither_chan(input logic [CHAN_W-1:0] chan,
                                                      input logic [3:0] m);
        logic signed [9:0] sum;
        sum = $signed({2'b00, chan}) + $signed({4'b0000, m, 2'b00}) - 10'sd32;
        if (sum < 10'sd0) begin
            dither_chan = '0;
        end else if (sum > 10'sd255) begin
            dither_chan = '1;
        end else begin
            dither_chan = sum[CHAN_W-1:0];
        end
    endfunction

    // Absolute difference of two channels.
    function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
        if (a > b) begin
            abs_diff = a - b;
        end else begin
            abs_diff = b - a;
        end
    endfunction

endpackage

/* rtl/ordered_dither_palette_quantizer.sv */
// Ordered-dither palette quantizer: top level with palette memory and scan pipeline.
// Depends on rtl/odpq_pkg.sv.
//
// Each pixel is compared against N = min(palette_count, PALETTE_DEPTH) palette entries;
//   an empty palette yields black.
// The single-port palette memory delivers one entry per cycle during the scan; a pixel or
//   palette write is accepted only in IDLE, after the last result went to the output register.
// Reset (synchronous, active low): counters cleared, palette_count 0, image_width 1,
//   dither on; the palette memory holds its contents and is undefined until written.
module ordered_dither_palette_quantizer
    import odpq_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
    parameter int MAX_WIDTH     = MAX_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [3:0] entry_index, [27:4] entry_color, [35:28] red, [43:36] green,
    // [51:44] blue, [55:52] zero
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // [0] action, [1] frame_start
    input  logic [S_TUSER_W-1:0]  s_axis_tuser,
    // output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [7:0] out_red, [15:8] out_green, [23:16] out_blue
    output logic [M_TDATA_W-1:0]  m_axis_tdata
);

    // Address of one palette entry, and a pointer that also reaches the depth itself
    localparam int AW     = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int IW     = $clog2(PALETTE_DEPTH + 1);
    // Column counter and the width used for the wrap compare
    localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CMP_W  = (CW + 1 > WIDTH_W + 1) ? CW + 1 : WIDTH_W + 1;

    // ------------------------------------------------------------------
    // Input field unpacking
    // ------------------------------------------------------------------
    logic               in_action;
    logic               in_frame_start;
    logic [INDEX_W-1:0] in_entry_index;
    logic [COLOR_W-1:0] in_entry_color;
    logic [CHAN_W-1:0]  in_red;
    logic [CHAN_W-1:0]  in_green;
    logic [CHAN_W-1:0]  in_blue;

    assign in_action      = s_axis_tuser[0];
    assign in_frame_start = s_axis_tuser[1];
    assign in_entry_index = s_axis_tdata[3:0];
    assign in_entry_color = s_axis_tdata[27:4];
    assign in_red         = s_axis_tdata[35:28];
    assign in_green       = s_axis_tdata[43:36];
    assign in_blue        = s_axis_tdata[51:44];

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0] r_palette_count;
    logic [WIDTH_W-1:0] r_image_width;
    logic               r_dither_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette_count <= '0;
            r_image_width   <= WIDTH_W'(1);
            r_dither_enable <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_PALETTE_COUNT: r_palette_count <= i_cfg_data[COUNT_W-1:0];
                CFG_IMAGE_WIDTH:   r_image_width   <= i_cfg_data[WIDTH_W-1:0];
                CFG_DITHER_ENABLE: r_dither_enable <= i_cfg_data[0];
                default: ;  // unused index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    t_state r_state;
    t_state n_state;

    logic [IW-1:0] r_rd_ptr;     // next entry to read
    logic [IW-1:0] r_count;      // entries to scan for this pixel
    logic          r_v1;         // memory read data valid
    logic          r_v2;         // registered squares valid
    logic          r_out_valid;

    logic accept;
    logic mem_we;
    logic mem_re;
    logic load_out;
    logic scan_idle;

    assign scan_idle = (r_rd_ptr == r_count) && !r_v1 && !r_v2;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && in_action == ACT_PIXEL) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_idle) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        mem_re        = 1'b0;
        load_out      = 1'b0;
        case (r_state)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_SCAN: mem_re        = (r_rd_ptr != r_count);
            ST_DONE: load_out      = !r_out_valid || m_axis_tready;
            default: ;
        endcase
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // Palette memory: one port, written in IDLE, read during SCAN
    // ------------------------------------------------------------------
    logic [COLOR_W-1:0]   mem [PALETTE_DEPTH];
    logic [COLOR_W-1:0]   r_rd_data;
    logic [AW+INDEX_W-1:0] slot_ext;
    logic [AW-1:0]        mem_addr;

    assign slot_ext = (AW + INDEX_W)'(in_entry_index);
    // A slot beyond the depth is dropped.
    assign mem_we   = accept && (in_action == ACT_WRITE)
                      && (int'(in_entry_index) < PALETTE_DEPTH);
    assign mem_addr = (r_state == ST_IDLE) ? slot_ext[AW-1:0] : r_rd_ptr[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= in_entry_color;
        end else if (mem_re) begin
            r_rd_data <= mem[mem_addr];
        end
    end

    // ------------------------------------------------------------------
    // Raster position and dither at pixel acceptance
    // ------------------------------------------------------------------
    logic [CW-1:0]    r_col;
    logic [1:0]       r_row;
    logic [CW-1:0]    n_col;
    logic [1:0]       n_row;
    logic [CW-1:0]    col_base;
    logic [1:0]       row_base;
    logic [CMP_W-1:0] eff_width;
    logic [3:0]       bayer_m;

    // Clear the position on a frame start before using it.
    assign col_base = in_frame_start ? '0 : r_col;
    assign row_base = in_frame_start ? 2'd0 : r_row;
    assign bayer_m  = BAYER_MAP[row_base][col_base[1:0]];

    always_comb begin
        // Clamp the programmed width into 1..MAX_WIDTH.
        if (r_image_width == '0) begin
            eff_width = CMP_W'(1);
        end else if (CMP_W'(r_image_width) > CMP_W'(MAX_WIDTH)) begin
            eff_width = CMP_W'(MAX_WIDTH);
        end else begin
            eff_width = CMP_W'(r_image_width);
        end
        // Wrap the column at the row end and advance the row phase.
        if (CMP_W'(col_base) + CMP_W'(1) >= eff_width) begin
            n_col = '0;
            n_row = row_base + 2'd1;
        end else begin
            n_col = col_base + CW'(1);
            n_row = row_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept && in_action == ACT_PIXEL) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Pixel channels after the optional dither offset
    logic [CHAN_W-1:0] r_pix_r;
    logic [CHAN_W-1:0] r_pix_g;
    logic [CHAN_W-1:0] r_pix_b;

    always_ff @(posedge i_clk) begin
        if (accept && in_action == ACT_PIXEL) begin
            if (r_dither_enable) begin
                r_pix_r <= dither_chan(in_red, bayer_m);
                r_pix_g <= dither_chan(in_green, bayer_m);
                r_pix_b <= dither_chan(in_blue, bayer_m);
            end else begin
                r_pix_r <= in_red;
                r_pix_g <= in_green;
                r_pix_b <= in_blue;
            end
        end
    end

    // ------------------------------------------------------------------
    // Scan pipeline: read entry, square channel errors, sum and compare
    // ------------------------------------------------------------------
    logic [SQ_W-1:0]    r_sq_r;
    logic [SQ_W-1:0]    r_sq_g;
    logic [SQ_W-1:0]    r_sq_b;
    logic [COLOR_W-1:0] r_cand;
    logic [DIST_W-1:0]  cand_dist;
    logic [DIST_W-1:0]  r_best_d;
    logic [COLOR_W-1:0] r_best;
    logic               r_found;
    logic [CHAN_W-1:0]  d_r;
    logic [CHAN_W-1:0]  d_g;
    logic [CHAN_W-1:0]  d_b;

    assign d_r       = abs_diff(r_rd_data[23:16], r_pix_r);
    assign d_g       = abs_diff(r_rd_data[15:8], r_pix_g);
    assign d_b       = abs_diff(r_rd_data[7:0], r_pix_b);
    assign cand_dist = DIST_W'(r_sq_r) + DIST_W'(r_sq_g) + DIST_W'(r_sq_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_v1 <= mem_re;
            r_v2 <= r_v1;
            if (accept && in_action == ACT_PIXEL) begin
                // Latch the clamped entry count and restart the scan.
                r_rd_ptr <= '0;
                r_found  <= 1'b0;
                if (int'(r_palette_count) > PALETTE_DEPTH) begin
                    r_count <= IW'(PALETTE_DEPTH);
                end else begin
                    r_count <= IW'(r_palette_count);
                end
            end else begin
                if (mem_re) begin
                    r_rd_ptr <= r_rd_ptr + IW'(1);
                end
                if (r_v2) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_sq_r <= d_r * d_r;
            r_sq_g <= d_g * d_g;
            r_sq_b <= d_b * d_b;
            r_cand <= r_rd_data;
        end
        if (accept && in_action == ACT_PIXEL) begin
            r_best   <= '0;   // black when the palette is empty
            r_best_d <= '0;
        end else if (r_v2 && (!r_found || cand_dist < r_best_d)) begin
            // Strict compare keeps the lowest-numbered entry on a tie.
            r_best   <= r_cand;
            r_best_d <= cand_dist;
        end
    end

    // ------------------------------------------------------------------
    // Output register: holds a result while the next pixel is taken in
    // ------------------------------------------------------------------
    logic [M_TDATA_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data <= {r_best[7:0], r_best[15:8], r_best[23:16]};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_ptr <= r_count)
        else $error("read pointer ran past the entry count");

    a_mem_one_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re))
        else $error("palette write and read in the same cycle");

    a_drained_at_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> (!r_v1 && !r_v2 && r_rd_ptr == r_count))
        else $error("result taken before the scan pipeline drained");

    a_found_when_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_count != '0) |-> r_found)
        else $error("non-empty palette scanned without a candidate");

    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_col) < CMP_W'(MAX_WIDTH))
        else $error("column counter beyond the maximum width");

endmodule
